@@ rtl/core/caq_pkg.sv @@
// camera attitude quaternion: shared types, constants and arithmetic helpers
package caq_pkg;

   // fixed point formats
   localparam int     OUT_FRAC_BITS = 15;
   localparam int     QF            = 30;
   localparam longint Q_ONE         = longint'(1) << QF;

   // angles in 1/2048 degree, half angles in 1/4096 degree
   localparam int TURN_FINE      = 737280;
   localparam int QUARTER_FINE   = 368640;
   localparam int EIGHTH_FINE    = 184320;
   localparam int WRAP_BIAS      = 4 * TURN_FINE;
   localparam int WRAP_STEPS     = 7;
   localparam int YAW_HALF_TURN  = 180 * 64;
   localparam int PITCH_LEVEL    = 90 * 64;

   // phase scaling: t = round(r * PI40 / (45 * 2^24)), PI40 = 45 * T_A + T_B
   localparam longint PI40     = 64'h3243F6A8885;
   localparam longint T_A      = PI40 / 45;
   localparam longint T_B      = PI40 % 45;
   localparam int     T_SPLIT  = 19;
   localparam longint T_A_HI   = T_A >> T_SPLIT;
   localparam longint T_A_LO   = T_A % (longint'(1) << T_SPLIT);
   localparam longint RECIP45  = (Q_ONE + 44) / 45;

   // series divisors k = odd * 2^shift, rounding offset k/2
   localparam int SIN_TERMS = 5;
   localparam int COS_TERMS = 6;
   localparam int     SIN_SHIFT [SIN_TERMS] = '{1, 3, 1, 2, 1};
   localparam int     SIN_ODD   [SIN_TERMS] = '{55, 9, 21, 5, 3};
   localparam int     SIN_HALF  [SIN_TERMS] = '{55, 36, 21, 10, 3};
   localparam longint SIN_RECIP [SIN_TERMS] =
      '{Q_ONE / 55, Q_ONE / 9, Q_ONE / 21, Q_ONE / 5, Q_ONE / 3};
   localparam int     COS_SHIFT [COS_TERMS] = '{2, 1, 3, 1, 2, 1};
   localparam int     COS_ODD   [COS_TERMS] = '{33, 45, 7, 15, 3, 1};
   localparam int     COS_HALF  [COS_TERMS] = '{66, 45, 28, 15, 6, 1};
   localparam longint COS_RECIP [COS_TERMS] =
      '{Q_ONE / 33, Q_ONE / 45, Q_ONE / 7, Q_ONE / 15, Q_ONE / 3, Q_ONE / 1};

   // sin/cos pipeline stage map
   localparam int SC_ITER0   = 6;
   localparam int SC_LAT     = SC_ITER0 + 3 * COS_TERMS + 2;
   localparam int SC_T_LAST  = SC_LAT - 3;
   localparam int SC_T2_LAST = SC_ITER0 - 1 + 3 * (COS_TERMS - 1);
   localparam int SC_FL_LAST = SC_LAT - 2;

   // top level stage map: two angle stages, sin/cos, four product stages, output
   localparam int SC_OUT_STAGE = SC_LAT + 1;
   localparam int PIPE_DEPTH   = 2 + SC_LAT + 5;

   typedef logic signed [15:0] angle_type;
   typedef logic signed [15:0] quat_type;
   typedef logic [19:0]        turn_type;
   typedef logic [22:0]        biased_type;
   typedef logic signed [31:0] trig_type;
   typedef logic [29:0]        frac_type;
   typedef logic [30:0]        poly_type;

   typedef struct packed {
      logic fold;
      logic upper;
   } sc_flag_type;

   // round half away from zero, then arithmetic shift right by n
   function automatic logic signed [63:0] rnd_away(input logic signed [63:0] v, input int n);
      logic signed [63:0] h;
      h = 64'sd1 <<< (n - 1);
      if (v >= 0) begin
         rnd_away = (v + h) >>> n;
      end else begin
         rnd_away = -((-v + h) >>> n);
      end
   endfunction

   // reduce a biased angle into one turn
   function automatic turn_type wrap_turn(input biased_type v);
      logic [2:0] k;
      biased_type r;
      k = '0;
      for (int j = 1; j <= WRAP_STEPS; j++) begin
         if (v >= 23'(j * TURN_FINE)) k = 3'(j);
      end
      r = v - 23'(int'(k) * TURN_FINE);
      return r[19:0];
   endfunction

   // clamp to the 16 bit output range
   function automatic quat_type sat_out(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         sat_out = 16'sh7FFF;
      end else if (v < -64'sd32768) begin
         sat_out = 16'sh8000;
      end else begin
         sat_out = v[15:0];
      end
   endfunction

endpackage

@@ rtl/core/caq_sincos.sv @@
// pipelined cos and sin of a half angle, Taylor series in Q30
module caq_sincos (
   input  logic              clock,
   input  logic              en,
   input  caq_pkg::turn_type angle_in,
   output caq_pkg::trig_type cos_out,
   output caq_pkg::trig_type sin_out
);
   import caq_pkg::*;

   // octant folding
   logic        upper_in;
   logic [18:0] r1;
   logic        fold_in;
   logic [17:0] r_in;
   logic [17:0] r_ff;

   always_comb begin
      upper_in = angle_in >= 20'(QUARTER_FINE);
      r1 = upper_in ? 19'(angle_in - 20'(QUARTER_FINE)) : angle_in[18:0];
      fold_in = r1 > 19'(EIGHTH_FINE);
      r_in = fold_in ? 18'(19'(QUARTER_FINE) - r1) : r1[17:0];
   end

   // flags, phase and squared phase travel with the data
   sc_flag_type fl_ff [0:SC_FL_LAST];
   frac_type    t_ff  [3:SC_T_LAST];
   frac_type    t2_ff [5:SC_T2_LAST];

   // phase scaling partial products
   logic [35:0] hi_in, hi_ff;
   logic [36:0] lo_in, lo_ff;
   logic [23:0] u_in, u_ff;
   logic [55:0] sum_in, sum_ff;
   logic [48:0] uqr_in, uqr_ff;
   frac_type    t_in;
   logic [59:0] tt_in, tt_ff;
   frac_type    t2_in;

   always_comb begin
      hi_in  = 36'(r_ff) * 36'(T_A_HI);
      lo_in  = 37'(r_ff) * 37'(T_A_LO);
      u_in   = 24'(r_ff) * 24'(T_B);
      sum_in = (56'(hi_ff) << T_SPLIT) + 56'(lo_ff);
      uqr_in = 49'(u_ff) * 49'(RECIP45);
      t_in   = 30'((sum_ff + (56'd1 << 23) + 56'(uqr_ff >> QF)) >> 24);
      tt_in  = 60'(t_ff[3]) * 60'(t_ff[3]);
      t2_in  = 30'((tt_ff + (60'd1 << (QF - 1))) >> QF);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff   <= r_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         u_ff   <= u_in;
         sum_ff <= sum_in;
         uqr_ff <= uqr_in;
         tt_ff  <= tt_in;
         fl_ff[0] <= '{fold: fold_in, upper: upper_in};
         for (int k = 1; k <= SC_FL_LAST; k++) fl_ff[k] <= fl_ff[k-1];
         t_ff[3] <= t_in;
         for (int k = 4; k <= SC_T_LAST; k++) t_ff[k] <= t_ff[k-1];
         t2_ff[5] <= t2_in;
         for (int k = 6; k <= SC_T2_LAST; k++) t2_ff[k] <= t2_ff[k-1];
      end
   end

   // Horner iterations: multiply, reciprocal estimate, remainder correction
   logic [60:0] prodc_ff [COS_TERMS];
   poly_type    xc_ff    [COS_TERMS];
   logic [61:0] qmc_ff   [COS_TERMS];
   poly_type    pc_ff    [COS_TERMS];
   logic [60:0] prods_ff [SIN_TERMS];
   poly_type    xs_ff    [SIN_TERMS];
   logic [61:0] qms_ff   [SIN_TERMS];
   poly_type    ps_ff    [COS_TERMS];

   for (genvar i = 0; i < COS_TERMS; i++) begin : g_iter
      poly_type    pc_prev;
      poly_type    ps_prev;
      logic [30:0] mc;
      logic [31:0] vc;
      poly_type    xc_in;
      logic [61:0] qmc_in;
      poly_type    q0c;
      logic [31:0] remc;
      poly_type    pc_in;

      if (i == 0) begin : g_first
         assign pc_prev = 31'(Q_ONE);
         assign ps_prev = 31'(Q_ONE);
      end else begin : g_next
         assign pc_prev = pc_ff[i-1];
         assign ps_prev = ps_ff[i-1];
      end

      // cos lane
      always_comb begin
         mc     = 31'((prodc_ff[i] + (61'd1 << (QF - 1))) >> QF);
         vc     = 32'(mc) + 32'(COS_HALF[i]);
         xc_in  = 31'(vc >> COS_SHIFT[i]);
         qmc_in = 62'(xc_in) * 62'(COS_RECIP[i]);
         q0c    = 31'(qmc_ff[i] >> QF);
         remc   = 32'(xc_ff[i]) - 32'(q0c) * 32'(COS_ODD[i]);
         pc_in  = (remc >= 32'(COS_ODD[i])) ? 31'(Q_ONE) - (q0c + 31'd1) : 31'(Q_ONE) - q0c;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            prodc_ff[i] <= 61'(t2_ff[SC_ITER0 - 1 + 3 * i]) * 61'(pc_prev);
            xc_ff[i]    <= xc_in;
            qmc_ff[i]   <= qmc_in;
            pc_ff[i]    <= pc_in;
         end
      end

      if (i < SIN_TERMS) begin : g_sin
         logic [30:0] ms;
         logic [31:0] vs;
         poly_type    xs_in;
         logic [61:0] qms_in;
         poly_type    q0s;
         logic [31:0] rems;
         poly_type    ps_in;

         always_comb begin
            ms     = 31'((prods_ff[i] + (61'd1 << (QF - 1))) >> QF);
            vs     = 32'(ms) + 32'(SIN_HALF[i]);
            xs_in  = 31'(vs >> SIN_SHIFT[i]);
            qms_in = 62'(xs_in) * 62'(SIN_RECIP[i]);
            q0s    = 31'(qms_ff[i] >> QF);
            rems   = 32'(xs_ff[i]) - 32'(q0s) * 32'(SIN_ODD[i]);
            ps_in  = (rems >= 32'(SIN_ODD[i])) ? 31'(Q_ONE) - (q0s + 31'd1)
                                                : 31'(Q_ONE) - q0s;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               prods_ff[i] <= 61'(t2_ff[SC_ITER0 - 1 + 3 * i]) * 61'(ps_prev);
               xs_ff[i]    <= xs_in;
               qms_ff[i]   <= qms_in;
               ps_ff[i]    <= ps_in;
            end
         end
      end else begin : g_hold
         // sin series is one term shorter: carry it along
         poly_type psa_ff;
         poly_type psb_ff;

         always_ff @(posedge clock) begin
            if (en) begin
               psa_ff   <= ps_prev;
               psb_ff   <= psa_ff;
               ps_ff[i] <= psb_ff;
            end
         end
      end
   end

   // final sin product and quadrant unfolding
   logic [60:0] sp_in, sp_ff;
   poly_type    cv_ff;
   poly_type    sv;
   trig_type    s_fold, c_fold;
   trig_type    cos_in, sin_in;
   trig_type    cos_ff, sin_ff;

   always_comb begin
      sp_in  = 61'(t_ff[SC_T_LAST]) * 61'(ps_ff[COS_TERMS-1]);
      sv     = 31'((sp_ff + (61'd1 << (QF - 1))) >> QF);
      s_fold = fl_ff[SC_FL_LAST].fold ? 32'(cv_ff) : 32'(sv);
      c_fold = fl_ff[SC_FL_LAST].fold ? 32'(sv) : 32'(cv_ff);
      sin_in = fl_ff[SC_FL_LAST].upper ? c_fold : s_fold;
      cos_in = fl_ff[SC_FL_LAST].upper ? -s_fold : c_fold;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff  <= sp_in;
         cv_ff  <= pc_ff[COS_TERMS-1];
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

@@ rtl/core/camera_attitude_quaternion.sv @@
// camera attitude quaternion from yaw, pitch and roll telemetry
// throughput: one beat per cycle; a stalled beat at the output freezes the whole pipeline
// the depth is set by the sin/cos units: a 6-term cos Horner series at three stages per term
// synchronous reset clears the pipeline valid bits and the mode register
module camera_attitude_quaternion (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  caq_pkg::angle_type req_aircraft_yaw,
   input  caq_pkg::angle_type req_gimbal_yaw,
   input  caq_pkg::angle_type req_yaw_encoder_count,
   input  caq_pkg::angle_type req_gimbal_pitch,
   input  caq_pkg::angle_type req_gimbal_roll,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output caq_pkg::quat_type  rsp_quat_w,
   output caq_pkg::quat_type  rsp_quat_x,
   output caq_pkg::quat_type  rsp_quat_y,
   output caq_pkg::quat_type  rsp_quat_z,
   input  logic               csr_write_en,
   input  logic               csr_write_data
);
   import caq_pkg::*;

   // mode register
   logic mode_in, mode_ff;
   assign mode_in = csr_write_en ? csr_write_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // pipeline advance and valid bits
   logic en;
   logic vld_ff [PIPE_DEPTH];

   assign en        = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // angles in 1/2048 degree, biased positive
   logic signed [24:0] yaw_s, pitch_s, roll_s;
   biased_type yaw_b_in, pitch_b_in, roll_b_in;
   biased_type yaw_b_ff, pitch_b_ff, roll_b_ff;

   always_comb begin
      yaw_s = mode_ff ? (25'(req_gimbal_yaw) + 25'sd11520) * 25'sd32
                      : 25'(req_aircraft_yaw) * 25'sd32 + 25'(req_yaw_encoder_count) * 25'sd45;
      pitch_s    = (25'(req_gimbal_pitch) - 25'(PITCH_LEVEL)) * 25'sd32;
      roll_s     = 25'(req_gimbal_roll) * 25'sd32;
      yaw_b_in   = 23'(yaw_s + 25'(WRAP_BIAS));
      pitch_b_in = 23'(pitch_s + 25'(WRAP_BIAS));
      roll_b_in  = 23'(roll_s + 25'(WRAP_BIAS));
   end

   // reduce into one turn
   turn_type yaw_t_in, pitch_t_in, roll_t_in;
   turn_type yaw_t_ff, pitch_t_ff, roll_t_ff;

   always_comb begin
      yaw_t_in   = wrap_turn(yaw_b_ff);
      pitch_t_in = wrap_turn(pitch_b_ff);
      roll_t_in  = wrap_turn(roll_b_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yaw_b_ff   <= yaw_b_in;
         pitch_b_ff <= pitch_b_in;
         roll_b_ff  <= roll_b_in;
         yaw_t_ff   <= yaw_t_in;
         pitch_t_ff <= pitch_t_in;
         roll_t_ff  <= roll_t_in;
      end
   end

   // half angle cos and sin per axis
   trig_type cz, sz, cy, sy, cx, sx;

   caq_sincos u_yaw (
      .clock    (clock),
      .en       (en),
      .angle_in (yaw_t_ff),
      .cos_out  (cz),
      .sin_out  (sz)
   );

   caq_sincos u_pitch (
      .clock    (clock),
      .en       (en),
      .angle_in (pitch_t_ff),
      .cos_out  (cy),
      .sin_out  (sy)
   );

   caq_sincos u_roll (
      .clock    (clock),
      .en       (en),
      .angle_in (roll_t_ff),
      .cos_out  (cx),
      .sin_out  (sx)
   );

   // yaw times pitch factor: products, then rounding
   logic signed [63:0] p1_in [4];
   logic signed [63:0] p1_ff [4];
   trig_type           h_in  [4];
   trig_type           h_ff  [4];
   trig_type           cx1_ff, sx1_ff, cx2_ff, sx2_ff;

   always_comb begin
      p1_in[0] = 64'(cz) * 64'(cy);
      p1_in[1] = 64'(sz) * 64'(sy);
      p1_in[2] = 64'(cz) * 64'(sy);
      p1_in[3] = 64'(sz) * 64'(cy);
      h_in[0]  = 32'(rnd_away(p1_ff[0], QF));
      h_in[1]  = 32'(rnd_away(p1_ff[1], QF));
      h_in[2]  = 32'(-rnd_away(p1_ff[2], QF));
      h_in[3]  = 32'(rnd_away(p1_ff[3], QF));
   end

   // times roll factor: products, then sums with rounding, then rounding and saturation to the 16 bit output
   logic signed [63:0] m_in  [8];
   logic signed [63:0] m_ff  [8];
   logic signed [33:0] r_in  [4];
   logic signed [33:0] r_ff  [4];
   quat_type           out_in [4];
   quat_type           out_ff [4];

   always_comb begin
      m_in[0] = 64'(h_ff[0]) * 64'(cx2_ff);
      m_in[1] = 64'(h_ff[1]) * 64'(sx2_ff);
      m_in[2] = 64'(h_ff[0]) * 64'(sx2_ff);
      m_in[3] = 64'(h_ff[1]) * 64'(cx2_ff);
      m_in[4] = 64'(h_ff[2]) * 64'(cx2_ff);
      m_in[5] = 64'(h_ff[3]) * 64'(sx2_ff);
      m_in[6] = 64'(h_ff[2]) * 64'(sx2_ff);
      m_in[7] = 64'(h_ff[3]) * 64'(cx2_ff);
      r_in[0] = 34'(rnd_away(m_ff[0] - m_ff[1], QF));
      r_in[1] = 34'(rnd_away(m_ff[2] + m_ff[3], QF));
      r_in[2] = 34'(rnd_away(m_ff[4] + m_ff[5], QF));
      r_in[3] = 34'(rnd_away(m_ff[7] - m_ff[6], QF));
      for (int k = 0; k < 4; k++) begin
         out_in[k] = sat_out(rnd_away(64'(r_ff[k]), QF - OUT_FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= p1_in;
         h_ff   <= h_in;
         cx1_ff <= cx;
         sx1_ff <= sx;
         cx2_ff <= cx1_ff;
         sx2_ff <= sx1_ff;
         m_ff   <= m_in;
         r_ff   <= r_in;
         out_ff <= out_in;
      end
   end

   assign rsp_quat_w = out_ff[0];
   assign rsp_quat_x = out_ff[1];
   assign rsp_quat_y = out_ff[2];
   assign rsp_quat_z = out_ff[3];

`ifndef NO_ASSERTIONS
   // an accepted beat enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted beat did not enter the pipeline");

   // when not stalled the last valid bit follows the one before it
   a_pipe_moves: assert property (@(posedge clock) disable iff (reset)
      (!req_stall) |=> (vld_ff[PIPE_DEPTH-1] == $past(vld_ff[PIPE_DEPTH-2])))
      else $error("pipeline did not advance while unstalled");

   // yaw half angle cos and sin stay within unit magnitude
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SC_OUT_STAGE] |->
         (cz <= 32'sd1073741824 && cz >= -32'sd1073741824 &&
          sz <= 32'sd1073741824 && sz >= -32'sd1073741824))
      else $error("yaw cos or sin out of unit range");
`endif

endmodule
